// ===== src/tadc_pkg.sv =====
`timescale 1ns / 1ps

package tadc_pkg;

    localparam int SAMPLE_W = 12;
    localparam int QUEUE_DEPTH = 2;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam logic [24:0] CENTI_OFFSET = 25'd27315;
    localparam logic [15:0] TEMP_MAX = 16'd32767;
    localparam logic [15:0] RES_MAX = 16'd65535;
    localparam logic [12:0] MV_MAX = 13'd8191;

    // register indexes of the configuration port
    typedef enum logic [2:0] {
        CFG_SERIES = 3'd0,
        CFG_VREF   = 3'd1,
        CFG_COEF_A = 3'd2,
        CFG_COEF_B = 3'd3,
        CFG_COEF_C = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [19:0]        series;
        logic [12:0]        vref;
        logic signed [47:0] coef_a;
        logic signed [47:0] coef_b;
        logic signed [47:0] coef_c;
    } cfg_t;

    // one queued request
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                zero;
    } entry_t;

    typedef struct packed {
        logic valid;
        logic full;
    } q_stat_t;

    typedef struct packed {
        logic        start;
        logic [64:0] num;
        logic [63:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [64:0] quo;
    } div_rsp_t;

endpackage

// ===== src/tadc_front.sv =====
`timescale 1ns / 1ps

module tadc_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [tadc_pkg::SAMPLE_W-1:0] adc_sample,
    input  tadc_pkg::q_stat_t             q_stat,
    output logic                          busy,
    output logic                          push,
    output logic                          front_valid,
    output tadc_pkg::entry_t              push_entry
);
    import tadc_pkg::*;

    logic   valid_reg;
    entry_t entry_reg;
    logic   accept;

    // hold one request until the queue has room
    assign busy        = valid_reg && q_stat.full;
    assign push        = valid_reg && !q_stat.full;
    assign accept      = start && !busy;
    assign push_entry  = entry_reg;
    assign front_valid = valid_reg;

    // capture and classify the sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (push)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            entry_reg.sample <= adc_sample;
            entry_reg.zero   <= (adc_sample == '0);
        end
    end

endmodule

// ===== src/tadc_queue.sv =====
`timescale 1ns / 1ps

module tadc_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tadc_pkg::entry_t  push_entry,
    input  logic              pop,
    output tadc_pkg::entry_t  pop_entry,
    output tadc_pkg::q_stat_t q_stat
);
    import tadc_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    entry_t           slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;

    assign q_stat.valid = (count_reg != '0);
    assign q_stat.full  = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign pop_entry    = slot_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== src/tadc_div.sv =====
`timescale 1ns / 1ps

module tadc_div (
    input  logic               clk,
    input  logic               rst_n,
    input  tadc_pkg::div_req_t req,
    output tadc_pkg::div_rsp_t rsp
);
    import tadc_pkg::*;

    localparam logic [6:0] DIV_STEPS = 7'd65;

    logic [64:0] num_reg;
    logic [63:0] den_reg;
    logic [63:0] rem_reg;
    logic [6:0]  count_reg;
    logic        done_reg;
    logic [64:0] trial;
    logic        fits;

    // restoring step, one quotient bit a cycle
    always_comb
    begin
        trial = {rem_reg, num_reg[64]};
        fits  = (trial >= {1'b0, den_reg});
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = num_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                count_reg <= DIV_STEPS;
            end
            else if (count_reg != '0)
            begin
                count_reg <= count_reg - 1'b1;
                if (count_reg == 7'd1)
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= req.num;
            den_reg <= req.den;
            rem_reg <= '0;
        end
        else if (count_reg != '0)
        begin
            if (fits)
            begin
                rem_reg <= 64'(trial - {1'b0, den_reg});
                num_reg <= {num_reg[63:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[63:0];
                num_reg <= {num_reg[63:0], 1'b0};
            end
        end
    end

endmodule

// ===== src/tadc_back.sv =====
`timescale 1ns / 1ps

module tadc_back #(
    parameter int ADC_BITS = 12
) (
    input  logic               clk,
    input  logic               rst_n,
    input  tadc_pkg::cfg_t     cfg,
    input  tadc_pkg::entry_t   pop_entry,
    input  tadc_pkg::q_stat_t  q_stat,
    output logic               pop,
    output tadc_pkg::div_req_t div_req,
    input  tadc_pkg::div_rsp_t div_rsp,
    output logic               done,
    output logic [15:0]        temperature_centi,
    output logic [15:0]        resistance_ohms,
    output logic [12:0]        node_millivolts,
    output logic               sample_error
);
    import tadc_pkg::*;

    localparam logic [15:0] FS16 = 16'((1 << ADC_BITS) - 1);
    // reciprocal of full scale, exact for products below 2^25
    localparam int MV_SHIFT = 25 + ADC_BITS;
    localparam logic [25:0] MV_RECIP =
        26'(((64'd1 << MV_SHIFT) + 64'(FS16) - 64'd1) / 64'(FS16));

    typedef enum logic [4:0] {
        ST_IDLE, ST_MV, ST_Q_WAIT, ST_NORM, ST_SQ, ST_LNMUL, ST_LNRND,
        ST_L2, ST_L3, ST_PB_MUL, ST_PB_ADD, ST_PC_MUL, ST_PC_ADD, ST_DSUM,
        ST_DCHK, ST_K_WAIT, ST_CMUL, ST_CENTI, ST_OUT
    } state_t;

    state_t              state_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic                zero_reg;
    logic [24:0]         mvp_reg;
    logic [15:0]         r_reg;
    logic [30:0]         x_reg;
    logic [23:0]         acc_reg;
    logic [4:0]          i_reg;
    logic [55:0]         lnp_reg;
    logic [19:0]         l_reg;
    logic [22:0]         l2_reg;
    logic [26:0]         l3_reg;
    logic [58:0]         hi_reg;
    logic [42:0]         lo_reg;
    logic signed [63:0]  pb_reg;
    logic signed [63:0]  pc_reg;
    logic signed [63:0]  d_reg;
    logic [38:0]         kp_reg;
    logic                done_reg;
    logic [15:0]         temp_reg;
    logic [15:0]         res_reg;
    logic [12:0]         mv_reg;
    logic                err_reg;
    div_req_t            div_req_reg;

    logic [47:0]        mag_b;
    logic [47:0]        mag_c;
    logic [3:0]         lead;
    logic [45:0]        x_shift;
    logic [61:0]        sq;
    logic [31:0]        sq_top;
    logic [64:0]        r_diff;
    logic [15:0]        r_sat;
    logic [63:0]        p_sum;
    logic [23:0]        k_round;
    logic signed [24:0] centi;
    logic [50:0]        mv_prod;
    logic [24:0]        mv_quo;

    assign pop               = (state_reg == ST_IDLE) && q_stat.valid;
    assign div_req           = div_req_reg;
    assign done              = done_reg;
    assign temperature_centi = temp_reg;
    assign resistance_ohms   = res_reg;
    assign node_millivolts   = mv_reg;
    assign sample_error      = err_reg;

    // coefficient magnitudes, leading one of r, log squaring, output arithmetic
    always_comb
    begin
        mag_b = cfg.coef_b[47] ? 48'(-cfg.coef_b) : 48'(cfg.coef_b);
        mag_c = cfg.coef_c[47] ? 48'(-cfg.coef_c) : 48'(cfg.coef_c);
        lead  = '0;
        for (int k = 0; k < 16; k++)
        begin
            if (r_reg[k])
            begin
                lead = 4'(k);
            end
        end
        x_shift = 46'(r_reg) << (5'd30 - {1'b0, lead});
        sq      = 62'(x_reg) * 62'(x_reg);
        sq_top  = sq[61:30];
        if (div_rsp.quo > 65'(cfg.series))
        begin
            r_diff = div_rsp.quo - 65'(cfg.series);
        end
        else
        begin
            r_diff = '0;
        end
        r_sat   = (r_diff > 65'(RES_MAX)) ? RES_MAX : r_diff[15:0];
        p_sum   = 64'(hi_reg) + 64'(lo_reg >> 16);
        k_round = 24'((40'(kp_reg) + 40'd32768) >> 16);
        centi   = $signed({1'b0, k_round}) - $signed(CENTI_OFFSET);
        mv_prod = 51'(mvp_reg) * 51'(MV_RECIP);
        mv_quo  = 25'(mv_prod >> MV_SHIFT);
    end

    // sequencer and datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            done_reg          <= 1'b0;
            div_req_reg.start <= 1'b0;
        end
        else
        begin
            done_reg          <= 1'b0;
            div_req_reg.start <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_stat.valid)
                    begin
                        sample_reg <= pop_entry.sample;
                        zero_reg   <= pop_entry.zero;
                        mvp_reg    <= 25'(pop_entry.sample) * 25'(cfg.vref);
                        state_reg  <= ST_MV;
                    end
                end
                ST_MV:
                begin
                    mv_reg <= (mv_quo > 25'(MV_MAX)) ? MV_MAX : mv_quo[12:0];
                    if (zero_reg)
                    begin
                        temp_reg  <= '0;
                        res_reg   <= '0;
                        err_reg   <= 1'b1;
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        err_reg           <= 1'b0;
                        div_req_reg.start <= 1'b1;
                        div_req_reg.num   <= 65'(cfg.series) * 65'(FS16);
                        div_req_reg.den   <= 64'(sample_reg);
                        state_reg         <= ST_Q_WAIT;
                    end
                end
                ST_Q_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        res_reg   <= r_sat;
                        r_reg     <= (r_sat == '0) ? 16'd1 : r_sat;
                        state_reg <= ST_NORM;
                    end
                end
                ST_NORM:
                begin
                    x_reg     <= x_shift[30:0];
                    acc_reg   <= {lead, 20'd0};
                    i_reg     <= 5'd19;
                    state_reg <= ST_SQ;
                end
                ST_SQ:
                begin
                    if (sq_top[31])
                    begin
                        x_reg          <= sq_top[31:1];
                        acc_reg[i_reg] <= 1'b1;
                    end
                    else
                    begin
                        x_reg <= sq_top[30:0];
                    end
                    i_reg <= i_reg - 1'b1;
                    if (i_reg == '0)
                    begin
                        state_reg <= ST_LNMUL;
                    end
                end
                ST_LNMUL:
                begin
                    lnp_reg   <= 56'(acc_reg) * 56'(LN2_Q32);
                    state_reg <= ST_LNRND;
                end
                ST_LNRND:
                begin
                    l_reg     <= 20'((57'(lnp_reg) + (57'd1 << 35)) >> 36);
                    state_reg <= ST_L2;
                end
                ST_L2:
                begin
                    l2_reg    <= 23'((40'(l_reg) * 40'(l_reg)) >> 16);
                    state_reg <= ST_L3;
                end
                ST_L3:
                begin
                    l3_reg    <= 27'((43'(l2_reg) * 43'(l_reg)) >> 16);
                    state_reg <= ST_PB_MUL;
                end
                ST_PB_MUL:
                begin
                    hi_reg    <= 59'(mag_b[47:16]) * 59'(l_reg);
                    lo_reg    <= 43'(mag_b[15:0]) * 43'(l_reg);
                    state_reg <= ST_PB_ADD;
                end
                ST_PB_ADD:
                begin
                    pb_reg    <= cfg.coef_b[47] ? -$signed(p_sum) : $signed(p_sum);
                    state_reg <= ST_PC_MUL;
                end
                ST_PC_MUL:
                begin
                    hi_reg    <= 59'(mag_c[47:16]) * 59'(l3_reg);
                    lo_reg    <= 43'(mag_c[15:0]) * 43'(l3_reg);
                    state_reg <= ST_PC_ADD;
                end
                ST_PC_ADD:
                begin
                    pc_reg    <= cfg.coef_c[47] ? -$signed(p_sum) : $signed(p_sum);
                    state_reg <= ST_DSUM;
                end
                ST_DSUM:
                begin
                    d_reg     <= 64'(cfg.coef_a) + pb_reg + pc_reg;
                    state_reg <= ST_DCHK;
                end
                ST_DCHK:
                begin
                    if (d_reg < 64'sd4294967296)
                    begin
                        temp_reg  <= TEMP_MAX;
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        div_req_reg.start <= 1'b1;
                        div_req_reg.num   <= 65'd1 << 64;
                        div_req_reg.den   <= d_reg;
                        state_reg         <= ST_K_WAIT;
                    end
                end
                ST_K_WAIT:
                begin
                    // kelvin reaches 2^32 when the denominator is exactly 2^32
                    if (div_rsp.done)
                    begin
                        kp_reg    <= 39'(div_rsp.quo[32:0]) * 39'd100;
                        state_reg <= ST_CMUL;
                    end
                end
                ST_CMUL:
                begin
                    state_reg <= ST_CENTI;
                end
                ST_CENTI:
                begin
                    temp_reg  <= (centi > $signed({9'd0, TEMP_MAX})) ? TEMP_MAX : centi[15:0];
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== src/thermistor_adc_to_temperature_top.sv =====
`timescale 1ns / 1ps
// the back end takes a new request only after the last one is done; a nonzero sample runs
//   the 65-step resistance divide, the 20-step log and, unless the denominator is out of
//   range, the 65-step kelvin divide, while a zero sample skips all three
// a two-entry queue and a front register take up to three requests ahead of the back end
// done pulses for one cycle per request; the receiver cannot stall
// reset: asynchronous active low, clears control state and loads register defaults
module thermistor_adc_to_temperature_top #(
    parameter int ADC_BITS = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [11:0] adc_sample,
    output logic        done,
    output logic [15:0] temperature_centi,
    output logic [15:0] resistance_ohms,
    output logic [12:0] node_millivolts,
    output logic        sample_error,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data
);
    import tadc_pkg::*;

    cfg_t     cfg_reg;
    q_stat_t  q_stat;
    entry_t   push_entry;
    entry_t   pop_entry;
    logic     push;
    logic     pop;
    logic     front_valid;
    div_req_t div_req;
    div_rsp_t div_rsp;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.series <= 20'd2490;
            cfg_reg.vref   <= 13'd3300;
            cfg_reg.coef_a <= '0;
            cfg_reg.coef_b <= '0;
            cfg_reg.coef_c <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SERIES: cfg_reg.series <= cfg_data[19:0];
                CFG_VREF:   cfg_reg.vref   <= cfg_data[12:0];
                CFG_COEF_A: cfg_reg.coef_a <= cfg_data;
                CFG_COEF_B: cfg_reg.coef_b <= cfg_data;
                CFG_COEF_C: cfg_reg.coef_c <= cfg_data;
                default:    ;
            endcase
        end
    end

    tadc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .adc_sample  (adc_sample),
        .q_stat      (q_stat),
        .busy        (busy),
        .push        (push),
        .front_valid (front_valid),
        .push_entry  (push_entry)
    );

    tadc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .q_stat     (q_stat)
    );

    tadc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    tadc_back #(
        .ADC_BITS (ADC_BITS)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg_reg),
        .pop_entry         (pop_entry),
        .q_stat            (q_stat),
        .pop               (pop),
        .div_req           (div_req),
        .div_rsp           (div_rsp),
        .done              (done),
        .temperature_centi (temperature_centi),
        .resistance_ohms   (resistance_ohms),
        .node_millivolts   (node_millivolts),
        .sample_error      (sample_error)
    );

`ifndef SYNTHESIS
    // a zero sample reports no temperature and no resistance
    assert property (@(posedge clk) disable iff (!rst_n)
        done && sample_error |-> temperature_centi == '0 && resistance_ohms == '0)
        else $error("zero sample result not cleared");

    // temperature never below absolute zero
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $signed(temperature_centi) >= -16'sd27315)
        else $error("temperature below range");

    // an accepted request is held in the front register next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> front_valid)
        else $error("accepted request lost");

    // a divider start is never answered immediately by done
    assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |=> !div_rsp.done)
        else $error("divider done too early");
`endif

endmodule
